/* rtl/wgm_pkg.sv */
package wgm_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int LEN_W = $clog2(MAX_PATTERN + 1);
   localparam int SYMBOL_W = 8;
   localparam int COUNT_W = 7;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

   localparam logic [SYMBOL_W-1:0] STAR_BYTE = 8'h2A;
   localparam logic [SYMBOL_W-1:0] ANY_BYTE = 8'h3F;

   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_APPEND  = 2'd1,
      KIND_RESTART = 2'd2,
      KIND_TEXT    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [SYMBOL_W-1:0] symbol;
   } cmd_type;

endpackage

/* rtl/wgm_if.sv */
interface wgm_req_if;
   import wgm_pkg::*;

   logic                valid;
   logic                ready;
   logic [1:0]          kind;
   logic [SYMBOL_W-1:0] symbol;

   modport source (output valid, output kind, output symbol, input ready);
   modport sink (input valid, input kind, input symbol, output ready);
endinterface

interface wgm_rsp_if;
   import wgm_pkg::*;

   logic               valid;
   logic               ready;
   logic               matched;
   logic               pattern_overflow;
   logic [COUNT_W-1:0] pattern_count;

   modport source (output valid, output matched, output pattern_overflow,
                   output pattern_count, input ready);
   modport sink (input valid, input matched, input pattern_overflow,
                 input pattern_count, output ready);
endinterface

/* rtl/wgm_ram.sv */
module wgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                                          clock,
   input  logic                                          we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                              wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                              rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/wgm_front.sv */
module wgm_front (
   input  logic             clock,
   input  logic             reset,
   wgm_req_if.sink          req_ch,
   output logic             cmd_valid,
   input  logic             cmd_ready,
   output wgm_pkg::cmd_type cmd
);
   import wgm_pkg::*;

   localparam logic [1:0] QUEUE_FULL = 2'd2;

   cmd_type    queue_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   cmd_type    entry;
   logic       push;
   logic       pop;

   assign req_ch.ready = (cnt_ff != QUEUE_FULL);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd = queue_ff[rd_ptr_ff];

   assign push = req_ch.valid && req_ch.ready;
   assign pop = cmd_valid && cmd_ready;

   // The kind code is decoded once here so that the back end sees a typed command.
   always_comb begin
      entry.kind = kind_type'(req_ch.kind);
      entry.symbol = req_ch.symbol;
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QUEUE_FULL)
      else $error("command queue count out of range");

   a_full_no_push: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == QUEUE_FULL && !pop) |=> cnt_ff == QUEUE_FULL)
      else $error("command queue lost an entry while full");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("command queue pointers disagree with count");

endmodule

/* rtl/wgm_back.sv */
module wgm_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  wgm_pkg::cmd_type cmd,
   wgm_rsp_if.source        rsp_ch
);
   import wgm_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DONE
   } state_type;

   state_type           state_ff, state_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                ovf_ff, ovf_in;
   logic                col0_ff, col0_in;
   logic                feed_ff, feed_in;
   logic [SYMBOL_W-1:0] sym_ff, sym_in;
   logic [LEN_W-1:0]    idx_ff, idx_in;
   logic                pend_ff, pend_in;
   logic [ADDR_W-1:0]   wr_addr_ff, wr_addr_in;
   logic                chain_ff, chain_in;
   logic                oldp_ff, oldp_in;
   logic                out_valid_ff, out_valid_in;
   logic                out_matched_ff, out_matched_in;
   logic                out_ovf_ff, out_ovf_in;
   logic [COUNT_W-1:0]  out_count_ff, out_count_in;

   logic                pat_we;
   logic [SYMBOL_W-1:0] pat_rdata;
   logic                col_we;
   logic                col_rdata;
   logic [ADDR_W-1:0]   rd_addr;
   logic                issue;
   logic                new_bit;

   // Column bit i (prefix of length i) lives at address i-1; bit zero is col0_ff.
   wgm_ram #(.WIDTH(SYMBOL_W), .DEPTH(MAX_PATTERN)) u_pattern_ram (
      .clock (clock),
      .we    (pat_we),
      .waddr (len_ff[ADDR_W-1:0]),
      .wdata (cmd.symbol),
      .raddr (rd_addr),
      .rdata (pat_rdata)
   );

   wgm_ram #(.WIDTH(1), .DEPTH(MAX_PATTERN)) u_column_ram (
      .clock (clock),
      .we    (col_we),
      .waddr (wr_addr_ff),
      .wdata (new_bit),
      .raddr (rd_addr),
      .rdata (col_rdata)
   );

   assign rd_addr = idx_ff[ADDR_W-1:0];

   // chain_ff carries the new bit of the previous prefix, oldp_ff its old bit.
   always_comb begin
      if (feed_ff) begin
         if (pat_rdata == STAR_BYTE) begin
            new_bit = chain_ff | col_rdata;
         end else if (pat_rdata == ANY_BYTE || pat_rdata == sym_ff) begin
            new_bit = oldp_ff;
         end else begin
            new_bit = 1'b0;
         end
      end else begin
         new_bit = chain_ff & (pat_rdata == STAR_BYTE);
      end
   end

   always_comb begin
      state_in = state_ff;
      len_in = len_ff;
      ovf_in = ovf_ff;
      col0_in = col0_ff;
      feed_in = feed_ff;
      sym_in = sym_ff;
      idx_in = idx_ff;
      pend_in = 1'b0;
      wr_addr_in = wr_addr_ff;
      chain_in = chain_ff;
      oldp_in = oldp_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      out_matched_in = out_matched_ff;
      out_ovf_in = out_ovf_ff;
      out_count_in = out_count_ff;
      cmd_ready = 1'b0;
      pat_we = 1'b0;
      col_we = 1'b0;
      issue = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd_ready = 1'b1;
            if (cmd_valid) begin
               idx_in = '0;
               state_in = ST_SWEEP;
               feed_in = 1'b0;
               chain_in = 1'b1;
               col0_in = 1'b1;
               unique case (cmd.kind)
                  KIND_CLEAR: begin
                     len_in = '0;
                     ovf_in = 1'b0;
                  end
                  KIND_APPEND: begin
                     if (len_ff < MAX_LEN) begin
                        pat_we = 1'b1;
                        len_in = len_ff + LEN_W'(1);
                     end else begin
                        ovf_in = 1'b1;
                     end
                  end
                  KIND_RESTART: begin
                     col0_in = 1'b1;
                  end
                  KIND_TEXT: begin
                     feed_in = 1'b1;
                     sym_in = cmd.symbol;
                     chain_in = 1'b0;
                     col0_in = 1'b0;
                     oldp_in = col0_ff;
                  end
                  default: begin
                     state_in = ST_SWEEP;
                  end
               endcase
            end
         end
         ST_SWEEP: begin
            issue = (idx_ff < len_ff);
            if (issue) begin
               idx_in = idx_ff + LEN_W'(1);
            end
            pend_in = issue;
            wr_addr_in = idx_ff[ADDR_W-1:0];
            if (pend_ff) begin
               col_we = 1'b1;
               chain_in = new_bit;
               oldp_in = col_rdata;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               out_valid_in = 1'b1;
               out_matched_in = chain_ff;
               out_ovf_in = ovf_ff;
               out_count_in = COUNT_W'(len_ff);
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         len_ff <= '0;
         ovf_ff <= 1'b0;
         col0_ff <= 1'b1;
         pend_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         col0_ff <= col0_in;
         pend_ff <= pend_in;
         out_valid_ff <= out_valid_in;
      end
      feed_ff <= feed_in;
      sym_ff <= sym_in;
      idx_ff <= idx_in;
      wr_addr_ff <= wr_addr_in;
      chain_ff <= chain_in;
      oldp_ff <= oldp_in;
      out_matched_ff <= out_matched_in;
      out_ovf_ff <= out_ovf_in;
      out_count_ff <= out_count_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.matched = out_matched_ff;
   assign rsp_ch.pattern_overflow = out_ovf_ff;
   assign rsp_ch.pattern_count = out_count_ff;

   a_len_cap: assert property (@(posedge clock) disable iff (reset)
      len_ff <= MAX_LEN)
      else $error("pattern length beyond capacity");

   a_ovf_full: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |-> (len_ff == MAX_LEN))
      else $error("overflow flagged while the pattern store has room");

   a_sweep_idx: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP) |-> (idx_ff <= len_ff))
      else $error("sweep index ran past the pattern length");

   a_result_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result loaded outside the completion state");

endmodule

/* rtl/wildcard_glob_matcher_top.sv */
// Channel   Direction  Fields
// req_ch    in         kind[1:0], symbol[7:0]
// rsp_ch    out        matched, pattern_overflow, pattern_count[6:0]
//
// In the back end each transaction sweeps the stored pattern: one position of the pattern and
// column memories is swept per cycle, and the column bit of each position is written once its
// read lands.
// Reset is synchronous and active high; it empties the pattern and the command queue.
// A two-entry command queue takes new transactions while the back end is busy, and the
// output register holds a finished result while the sink stalls.
module wildcard_glob_matcher_top (
   input logic        clock,
   input logic        reset,
   wgm_req_if.sink    req_ch,
   wgm_rsp_if.source  rsp_ch
);
   import wgm_pkg::*;

   logic    cmd_valid;
   logic    cmd_ready;
   cmd_type cmd;

   wgm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   wgm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .rsp_ch    (rsp_ch)
   );

endmodule

/* test/wildcard_glob_matcher_checker.sv */
`timescale 1ns / 100ps

module wildcard_glob_matcher_checker (
   input  logic clock,
   input  logic reset,
   wgm_req_if   req_ch,
   wgm_rsp_if   rsp_ch,
   output int   errors,
   output int   pending
);
   import wgm_pkg::*;

   typedef struct packed {
      logic               matched;
      logic               overflow;
      logic [COUNT_W-1:0] count;
   } match_result_type;

   logic [SYMBOL_W-1:0] pattern_bytes [MAX_PATTERN];
   int unsigned         pattern_len;
   logic [MAX_PATTERN:0] prefix_bits;
   logic                overflow_seen;
   match_result_type    expected_q [$];

   // A restarted column matches the empty text: only the leading run of stars can follow prefix 0.
   function automatic void rescan_prefixes();
      prefix_bits = '0;
      prefix_bits[0] = 1'b1;
      for (int i = 1; i <= MAX_PATTERN; i++) begin
         if (i <= pattern_len && pattern_bytes[i-1] == STAR_BYTE) begin
            prefix_bits[i] = prefix_bits[i-1];
         end
      end
   endfunction

   // A star always follows the star rule, even when the text byte is itself a star.
   function automatic void advance_prefixes(input logic [SYMBOL_W-1:0] text_byte);
      logic [MAX_PATTERN:0] next_bits;
      logic [SYMBOL_W-1:0]  p;
      next_bits = '0;
      for (int i = 1; i <= pattern_len; i++) begin
         p = pattern_bytes[i-1];
         if (p == STAR_BYTE) begin
            next_bits[i] = next_bits[i-1] | prefix_bits[i];
         end else if (p == ANY_BYTE || p == text_byte) begin
            next_bits[i] = prefix_bits[i-1];
         end
      end
      prefix_bits = next_bits;
   endfunction

   function automatic match_result_type apply_command(input kind_type kind,
                                                      input logic [SYMBOL_W-1:0] symbol);
      match_result_type r;
      case (kind)
         KIND_CLEAR: begin
            pattern_len = 0;
            overflow_seen = 1'b0;
            rescan_prefixes();
         end
         KIND_APPEND: begin
            if (pattern_len < MAX_PATTERN) begin
               pattern_bytes[pattern_len] = symbol;
               pattern_len++;
            end else begin
               overflow_seen = 1'b1;
            end
            rescan_prefixes();
         end
         KIND_RESTART: begin
            rescan_prefixes();
         end
         default: begin
            advance_prefixes(symbol);
         end
      endcase
      r.matched = prefix_bits[pattern_len];
      r.overflow = overflow_seen;
      r.count = COUNT_W'(pattern_len);
      return r;
   endfunction

   always @(posedge clock) begin
      match_result_type want;
      if (reset) begin
         pattern_len = 0;
         overflow_seen = 1'b0;
         prefix_bits = '0;
         prefix_bits[0] = 1'b1;
         expected_q.delete();
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_q.push_back(apply_command(kind_type'(req_ch.kind), req_ch.symbol));
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result transaction: matched %b overflow %b count %0d",
                        $time, rsp_ch.matched, rsp_ch.pattern_overflow, rsp_ch.pattern_count);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.matched !== want.matched) begin
                  $display("%0t: matched: expected %b, actual %b",
                           $time, want.matched, rsp_ch.matched);
                  errors++;
               end
               if (rsp_ch.pattern_overflow !== want.overflow) begin
                  $display("%0t: pattern_overflow: expected %b, actual %b",
                           $time, want.overflow, rsp_ch.pattern_overflow);
                  errors++;
               end
               if (rsp_ch.pattern_count !== want.count) begin
                  $display("%0t: pattern_count: expected %0d, actual %0d",
                           $time, want.count, rsp_ch.pattern_count);
                  errors++;
               end
            end
         end
      end
      pending <= expected_q.size();
   end

endmodule

/* test/wildcard_glob_matcher_top_test.sv */
`timescale 1ns / 100ps

module wildcard_glob_matcher_top_test;
   import wgm_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int ITEM_TARGET = 1250;
   localparam int CALM_TAIL = 150;
   localparam int HOLD_AT = 400;
   localparam int HOLD_CYCLES = 300;
   localparam int LIMIT_CYCLES = 500_000;

   logic clock = 1'b0;
   logic reset;
   int   errors;
   int   pending;
   int   sent = 0;
   int   sequences = 0;
   int   capacity_runs = 0;
   bit   calm = 1'b0;
   bit   want_hold = 1'b0;
   bit   hold_done = 1'b0;

   wgm_req_if req_ch ();
   wgm_rsp_if rsp_ch ();

   wildcard_glob_matcher_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   wildcard_glob_matcher_checker u_checker (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .errors  (errors),
      .pending (pending)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   initial begin
      #(LIMIT_CYCLES * CLOCK_PERIOD);
      $display("%0t: run timed out with %0d results outstanding", $time, pending);
      $display("== FAIL ==");
      $finish;
   end

   // Offers one transaction, optionally after a short gap, and returns at the edge that takes it.
   task automatic put(input kind_type kind, input logic [SYMBOL_W-1:0] symbol);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind <= kind;
      req_ch.symbol <= symbol;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      sent++;
   endtask

   function automatic logic [SYMBOL_W-1:0] pattern_byte();
      int r;
      r = $urandom_range(0, 11);
      if (r < 3) return STAR_BYTE;
      if (r < 5) return ANY_BYTE;
      if (r == 11) return SYMBOL_W'($urandom_range(0, 255));
      return SYMBOL_W'(8'h61 + $urandom_range(0, 2));
   endfunction

   function automatic logic [SYMBOL_W-1:0] text_byte();
      int r;
      r = $urandom_range(0, 15);
      if (r == 0) return STAR_BYTE;
      if (r == 1) return ANY_BYTE;
      if (r == 2) return SYMBOL_W'($urandom_range(0, 255));
      return SYMBOL_W'(8'h61 + $urandom_range(0, 2));
   endfunction

   // Clear, load a pattern, then feed one or two texts, most of them built to fit the pattern.
   task automatic run_sequence(input int plen);
      logic [SYMBOL_W-1:0] pat_q [$];
      logic [SYMBOL_W-1:0] text_q [$];
      logic [SYMBOL_W-1:0] b;
      int texts;
      put(KIND_CLEAR, SYMBOL_W'($urandom_range(0, 255)));
      for (int i = 0; i < plen; i++) begin
         b = pattern_byte();
         pat_q.push_back(b);
         put(KIND_APPEND, b);
      end
      texts = $urandom_range(1, 2);
      for (int t = 0; t < texts; t++) begin
         if (t > 0 || $urandom_range(0, 1) == 1) begin
            put(KIND_RESTART, SYMBOL_W'($urandom_range(0, 255)));
         end
         text_q.delete();
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(0, 10)) text_q.push_back(text_byte());
         end else begin
            foreach (pat_q[i]) begin
               // Bytes past capacity were dropped by the block, so they shape no text.
               if (i < MAX_PATTERN) begin
                  if (pat_q[i] == STAR_BYTE) begin
                     repeat ($urandom_range(0, 3)) text_q.push_back(text_byte());
                  end else if (pat_q[i] == ANY_BYTE) begin
                     text_q.push_back(text_byte());
                  end else begin
                     text_q.push_back(pat_q[i]);
                  end
               end
            end
            if (text_q.size() > 0 && $urandom_range(0, 2) == 0) begin
               text_q[$urandom_range(0, text_q.size() - 1)] = text_byte();
            end
         end
         foreach (text_q[i]) put(KIND_TEXT, text_q[i]);
      end
      sequences++;
   endtask

   initial begin
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (want_hold) begin
            want_hold = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_ch.ready <= 1'b1;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   initial begin
      reset <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind <= KIND_CLEAR;
      req_ch.symbol <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty pattern: any text byte kills the match, a restart brings it back.
      put(KIND_TEXT, 8'h61);
      put(KIND_RESTART, 8'hFF);
      put(KIND_CLEAR, 8'hFF);
      // Stars against star, zero and all-ones text bytes.
      put(KIND_APPEND, STAR_BYTE);
      put(KIND_APPEND, STAR_BYTE);
      put(KIND_TEXT, STAR_BYTE);
      put(KIND_TEXT, 8'h00);
      put(KIND_TEXT, 8'hFF);
      put(KIND_CLEAR, 8'h00);
      put(KIND_APPEND, ANY_BYTE);
      put(KIND_APPEND, 8'h00);
      put(KIND_APPEND, 8'hFF);
      put(KIND_RESTART, 8'h00);
      put(KIND_TEXT, 8'h41);
      put(KIND_TEXT, 8'h00);
      put(KIND_TEXT, 8'hFF);
      put(KIND_TEXT, 8'hFF);
      put(KIND_RESTART, 8'hFF);
      // An append in the middle of a text restarts it.
      put(KIND_TEXT, 8'h7E);
      put(KIND_APPEND, STAR_BYTE);
      put(KIND_TEXT, ANY_BYTE);
      put(KIND_TEXT, 8'h00);
      put(KIND_TEXT, 8'hFF);

      // Fill the store past capacity once early; later such runs are rare.
      run_sequence(MAX_PATTERN + 2);
      capacity_runs++;

      while (sent < ITEM_TARGET) begin
         if (sent >= HOLD_AT && !hold_done) begin
            hold_done = 1'b1;
            want_hold = 1'b1;
         end
         calm = (sent >= ITEM_TARGET - CALM_TAIL);
         if ($urandom_range(0, 7) == 0) begin
            repeat ($urandom_range(1, 6)) begin
               put(kind_type'(2'($urandom_range(0, 3))), SYMBOL_W'($urandom_range(0, 255)));
            end
         end
         if ($urandom_range(0, 59) == 0) begin
            run_sequence(MAX_PATTERN + $urandom_range(1, 3));
            capacity_runs++;
         end else if ($urandom_range(0, 5) == 0) begin
            run_sequence($urandom_range(7, 16));
         end else begin
            run_sequence($urandom_range(0, 6));
         end
      end
      req_ch.valid <= 1'b0;

      do @(posedge clock); while (pending != 0);
      repeat (MAX_PATTERN + 8) @(posedge clock);

      $display("Sent %0d transactions: directed corner cases, then %0d clear/pattern/text runs,",
               sent, sequences);
      $display("%0d of them past capacity, with noise bursts and one long result stall.",
               capacity_runs);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", errors);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
